// ===== rtl/hscd_pkg.sv =====
`default_nettype none
package hscd_pkg;
  // Slots are numbered 1..SlotCount. SlotCount must be a power of two: the home slot
  // takes the low hash bits.
  localparam int SlotCount = 1024;
  localparam int SlotW = $clog2(SlotCount + 1);
  localparam int HomeW = $clog2(SlotCount);
  localparam logic [31:0] NoneSector = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_LOOKUP = 3'd0,
    OP_FILL   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_FLUSH  = 3'd3,
    OP_CLEAN  = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HASH,
    ST_PROBE_RD,
    ST_PROBE_CK,
    ST_CHAIN_RD,
    ST_CHAIN_CK,
    ST_FREE_RD,
    ST_FREE_CK,
    ST_COMMIT,
    ST_SLOT_RD,
    ST_SLOT_CK,
    ST_CLEAR,
    ST_DONE
  } state_t;

  // One round of the one-at-a-time hash over a single byte.
  function automatic logic [31:0] oaat_round(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] t;
    t = h + {24'd0, b};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic logic [31:0] oaat_final(input logic [31:0] h);
    logic [31:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/hscd_ram.sv =====
`default_nettype none
module hscd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = $clog2(Depth)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/hscd_hash.sv =====
`default_nettype none
module hscd_hash
  import hscd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [31:0]      key,
  output logic                  done,
  output logic      [SlotW-1:0] home
);
  logic [31:0] h;
  logic [31:0] k;
  logic [2:0]  step;
  logic        run;
  logic        fin;

  assign fin = run && (step == 3'd4);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= fin;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
        h    <= '0;
        k    <= key;
      end else if (run) begin
        if (!fin) begin
          h    <= oaat_round(h, k[7:0]);
          k    <= k >> 8;
          step <= step + 3'd1;
        end else begin
          h    <= oaat_final(h);
          run  <= 1'b0;
        end
      end
    end
  end

  assign home = SlotW'(h[HomeW-1:0]) + SlotW'(1);
endmodule
`default_nettype wire

// ===== rtl/hashed_sector_cache_directory.sv =====
// Sector cache hash directory. Pulse start while busy is low; the result
// appears on the output ports with done high for exactly one cycle and must
// be taken then: the receiver cannot hold results off. After reset a
// clearing pass writes every slot, 0 to SlotCount, with busy high. The
// key is hashed first; the probe then reads slots upward from the home
// slot, wrapping, and follows the chain links; adding behind an existing
// chain also scans down from the top slot for a free one. Writing an entry
// is a single write, plus a second one that links the chain tail when
// there is one. Flush probe and mark clean read the selected slot without
// hashing, and unknown opcodes go straight to done. All of this runs
// through one directory memory with one read and one write port, so
// latency follows table occupancy. Busy is low during the done cycle, so
// the next item can be taken at the edge that ends it.
`default_nettype none
module hashed_sector_cache_directory
  import hscd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [2:0]       opcode,
  input  wire logic [31:0]      sector_number,
  input  wire logic [10:0]      slot_select,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_write_through_mode,
  output logic                  done,
  output logic                  hit,
  output logic      [10:0]      slot,
  output logic                  entry_made,
  output logic                  need_backing_write,
  output logic                  dirty_found,
  output logic      [31:0]      probed_sector,
  output logic      [10:0]      cached_total
);
  localparam int EntW = SlotW + SlotW + 32 + 1;
  localparam logic [SlotW-1:0] Last = SlotW'(SlotCount);
  localparam logic [SlotW:0] CntMax = (SlotW+1)'(SlotCount);

  typedef struct packed {
    logic [SlotW-1:0] hsh;
    logic [SlotW-1:0] lnk;
    logic [31:0]      sec;
    logic             dty;
  } ent_t;

  state_t state, state_next;
  logic wt;
  logic [2:0] op;
  logic [31:0] key;
  logic [10:0] sel;
  logic [SlotW-1:0] hv, cur, tail, tgt;
  logic [SlotW:0] cnt, occ;
  logic found, r_hit, r_made, r_need, r_dirty;
  logic [SlotW-1:0] r_slot;
  logic [31:0] r_psec;
  ent_t tail_ent;

  logic we;
  logic [SlotW-1:0] waddr, raddr;
  ent_t wdata, rd;
  logic [EntW-1:0] rdata;
  assign rd = ent_t'(rdata);

  hscd_ram #(.Width(EntW), .Depth(SlotCount + 1)) u_ram (
    .clk, .we, .waddr, .wdata(EntW'(wdata)), .raddr, .rdata
  );

  logic h_start, h_done;
  logic [SlotW-1:0] h_home;
  hscd_hash u_hash (
    .clk, .rst, .start(h_start), .key(sector_number), .done(h_done), .home(h_home)
  );

  logic sel_ok;
  assign sel_ok = (sel != 11'd0) && ({{(32-11){1'b0}}, sel} <= 32'(SlotCount));
  logic [SlotW-1:0] sel_s;
  assign sel_s = SlotW'(sel);
  logic [SlotW-1:0] cur_inc;
  assign cur_inc = (cur == Last) ? SlotW'(1) : cur + SlotW'(1);
  logic link_bad;
  assign link_bad = (rd.lnk == '0) || (rd.lnk > Last);
  logic is_add;
  assign is_add = (op == OP_FILL) || (op == OP_WRITE);
  logic full;
  assign full = occ >= CntMax;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (start) begin
        if (opcode == OP_LOOKUP || opcode == OP_FILL || opcode == OP_WRITE)
          state_next = ST_HASH;
        else if (opcode == OP_FLUSH || opcode == OP_CLEAN)
          state_next = ST_SLOT_RD;
        else
          state_next = ST_DONE;
      end
      ST_HASH:     if (h_done) state_next = ST_PROBE_RD;
      ST_PROBE_RD: state_next = ST_PROBE_CK;
      ST_PROBE_CK: begin
        if (rd.hsh == '0)
          state_next = (found || !is_add || full) ? ST_DONE : ST_COMMIT;
        else if (rd.hsh == hv) state_next = ST_CHAIN_CK;
        else if (cnt + 1'b1 >= CntMax) state_next = ST_DONE;
        else state_next = ST_PROBE_RD;
      end
      ST_CHAIN_RD: state_next = ST_CHAIN_CK;
      ST_CHAIN_CK: begin
        if (rd.sec == key) state_next = (op == OP_WRITE && !wt) ? ST_COMMIT : ST_DONE;
        else if (rd.lnk == '0)
          state_next = (!is_add || full) ? ST_DONE : ST_FREE_RD;
        else if (link_bad || cnt + 1'b1 >= CntMax) state_next = ST_DONE;
        else state_next = ST_CHAIN_RD;
      end
      ST_FREE_RD: state_next = ST_FREE_CK;
      ST_FREE_CK: begin
        if (rd.hsh == '0) state_next = ST_COMMIT;
        else if (cur == SlotW'(1)) state_next = ST_DONE;
        else state_next = ST_FREE_RD;
      end
      ST_COMMIT:  state_next = (!found && tail != '0 && tgt != '0) ? ST_COMMIT : ST_DONE;
      ST_SLOT_RD: state_next = ST_SLOT_CK;
      ST_SLOT_CK: state_next = ST_DONE;
      ST_CLEAR:   if (cur == Last) state_next = ST_IDLE;
      ST_DONE:    state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    we      = 1'b0;
    waddr   = cur;
    wdata   = '{hsh: '0, lnk: '0, sec: NoneSector, dty: 1'b0};
    raddr   = cur;
    h_start = (state == ST_IDLE) && start && (state_next == ST_HASH);
    unique case (state)
      ST_CLEAR: we = 1'b1;
      ST_SLOT_RD: raddr = sel_s;
      ST_SLOT_CK: begin
        if (op == OP_CLEAN && sel_ok) begin
          we    = 1'b1;
          waddr = sel_s;
          wdata = '{hsh: rd.hsh, lnk: rd.lnk, sec: rd.sec, dty: 1'b0};
        end
      end
      ST_CHAIN_CK: begin
        if (rd.sec != key && rd.lnk == '0) raddr = Last;
      end
      ST_COMMIT: begin
        we = 1'b1;
        if (found) begin
          waddr = cur;
          wdata = '{hsh: rd.hsh, lnk: rd.lnk, sec: rd.sec, dty: 1'b1};
        end else if (tail != '0 && tgt == '0) begin
          waddr = tail;
          wdata = '{hsh: tail_ent.hsh, lnk: r_slot, sec: tail_ent.sec, dty: tail_ent.dty};
        end else begin
          waddr = tgt;
          wdata = '{hsh: hv, lnk: '0, sec: key, dty: (op == OP_WRITE) && !wt};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cur   <= '0;
      occ   <= '0;
      wt    <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_DONE);
      if (cfg_valid && cfg_ready) wt <= cfg_write_through_mode;
      unique case (state)
        ST_CLEAR: cur <= cur + SlotW'(1);
        ST_IDLE: if (start) begin
          op <= opcode; key <= sector_number; sel <= slot_select;
          found <= 1'b0; tail <= '0; tgt <= '0; cnt <= '0;
          r_hit <= 1'b0; r_made <= 1'b0; r_slot <= '0;
          r_dirty <= 1'b0; r_psec <= '0;
        end
        ST_HASH: if (h_done) begin
          hv <= h_home; cur <= h_home;
        end
        ST_PROBE_CK: begin
          if (rd.hsh == '0) tgt <= cur;
          else if (rd.hsh != hv) begin
            cur <= cur_inc; cnt <= cnt + 1'b1;
          end else cnt <= '0;
        end
        ST_CHAIN_CK: begin
          if (rd.sec == key) begin
            found <= 1'b1; r_hit <= 1'b1; r_slot <= cur;
          end else if (rd.lnk == '0) begin
            tail <= cur; tail_ent <= rd; cur <= Last;
          end else begin
            cur <= rd.lnk; cnt <= cnt + 1'b1;
          end
        end
        ST_FREE_CK: begin
          if (rd.hsh == '0) tgt <= cur;
          else cur <= cur - SlotW'(1);
        end
        ST_COMMIT: begin
          if (!found) begin
            if (tail != '0 && tgt != '0) begin
              // new entry written now; link the tail next cycle
              tgt <= '0;
              r_slot <= tgt;
            end else if (tail == '0) begin
              r_slot <= tgt;
            end
            if (tail == '0 || tgt != '0) begin
              r_made <= 1'b1;
              occ <= occ + 1'b1;
            end
          end
        end
        ST_SLOT_CK: begin
          if (op == OP_FLUSH) begin
            if (sel_ok) begin
              r_psec <= rd.sec;
              if (rd.hsh != '0 && rd.dty) begin
                r_dirty <= 1'b1; r_slot <= sel_s;
              end
            end else r_psec <= NoneSector;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    r_need = 1'b0;
    if (op == OP_WRITE) r_need = wt || (r_slot == '0);
    else if (op == OP_FLUSH) r_need = r_dirty;
  end

  assign hit                = r_hit;
  assign slot               = 11'(r_slot);
  assign entry_made         = r_made;
  assign need_backing_write = r_need;
  assign dirty_found        = r_dirty;
  assign probed_sector      = r_psec;
  assign cached_total       = 11'(occ);

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_busy_while_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> busy) else $error("idle during result");
  a_made_has_slot: assert property (@(posedge clk) disable iff (rst)
    (done && entry_made) |-> (slot != 11'd0)) else $error("entry without slot");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CntMax) else $error("count overflow");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import hscd_pkg::*;

  localparam int Slots = 1024;
  localparam int StallLimit = 40000;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] sec;
    logic [10:0] sel;
  } item_t;

  typedef struct {
    logic        hit;
    logic [10:0] slot;
    logic        made;
    logic        need;
    logic        dirty;
    logic [31:0] psec;
    logic [10:0] total;
  } outcome_t;

  logic clk, rst, start, busy, cfg_valid, cfg_ready, cfg_wt;
  logic [2:0] opcode;
  logic [31:0] sector_number;
  logic [10:0] slot_select;
  logic done, hit, entry_made, need_backing_write, dirty_found;
  logic [10:0] slot, cached_total;
  logic [31:0] probed_sector;

  hashed_sector_cache_directory dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .sector_number(sector_number), .slot_select(slot_select),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_write_through_mode(cfg_wt),
    .done(done), .hit(hit), .slot(slot), .entry_made(entry_made),
    .need_backing_write(need_backing_write), .dirty_found(dirty_found),
    .probed_sector(probed_sector), .cached_total(cached_total)
  );

  item_t pending[$];
  outcome_t awaited[$];
  int errors = 0;
  int cfg_writes = 0;
  int gap = 0;
  int stall = 0;
  bit quiet = 0;
  logic took = 0;

  logic [10:0] dir_hash[Slots+1];
  logic [10:0] dir_link[Slots+1];
  logic [31:0] dir_sector[Slots+1];
  logic        dir_dirty[Slots+1];
  logic [10:0] dir_count;
  logic        wt_mode;

  logic [31:0] pool[$];
  logic [31:0] twins[$];

  function automatic logic [10:0] home_of(logic [31:0] k);
    logic [31:0] h;
    h = 0;
    for (int b = 0; b < 4; b++) begin
      h = h + k[b*8 +: 8];
      h = h + (h << 10);
      h = h ^ (h >> 6);
    end
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return 11'((h % Slots) + 1);
  endfunction

  function automatic logic [10:0] next_slot(logic [10:0] s);
    return 11'((s % Slots) + 1);
  endfunction

  function automatic logic [10:0] chain_head(logic [10:0] hv, output logic [10:0] empty);
    logic [10:0] cur;
    cur = hv;
    empty = 0;
    for (int n = 0; n < Slots; n++) begin
      if (dir_hash[cur] == 0) begin
        empty = cur;
        return 0;
      end
      if (dir_hash[cur] == hv) return cur;
      cur = next_slot(cur);
    end
    return 0;
  endfunction

  function automatic logic [10:0] find_sector(logic [31:0] sec);
    logic [10:0] cur, empty, nx;
    cur = chain_head(home_of(sec), empty);
    if (cur == 0) return 0;
    for (int n = 0; n < Slots; n++) begin
      if (dir_sector[cur] == sec) return cur;
      nx = dir_link[cur];
      if (nx == 0 || nx > Slots) return 0;
      cur = nx;
    end
    return 0;
  endfunction

  function automatic logic [10:0] link_in(logic [31:0] sec);
    logic [10:0] hv, head, empty, tgt, tail, nx;
    tail = 0;
    if (dir_count >= Slots) return 0;
    hv = home_of(sec);
    head = chain_head(hv, empty);
    if (head == 0) begin
      if (empty == 0) return 0;
      tgt = empty;
    end else begin
      tail = head;
      for (int n = 0; n <= Slots; n++) begin
        if (n >= Slots) return 0;
        nx = dir_link[tail];
        if (nx == 0) break;
        if (nx > Slots) return 0;
        tail = nx;
      end
      tgt = 0;
      for (int s = Slots; s > 0; s--) begin
        if (dir_hash[s] == 0) begin
          tgt = 11'(s);
          break;
        end
      end
      if (tgt == 0) return 0;
    end
    dir_hash[tgt] = hv;
    dir_sector[tgt] = sec;
    dir_link[tgt] = 0;
    dir_dirty[tgt] = 0;
    if (tail != 0) dir_link[tail] = tgt;
    dir_count = dir_count + 1;
    return tgt;
  endfunction

  function automatic outcome_t apply_item(item_t it);
    outcome_t r;
    bit in_range;
    r = '{default: '0};
    in_range = it.sel >= 1 && it.sel <= Slots;
    case (it.op)
      OP_LOOKUP: begin
        r.slot = find_sector(it.sec);
        r.hit = r.slot != 0;
      end
      OP_FILL, OP_WRITE: begin
        r.slot = find_sector(it.sec);
        if (r.slot != 0) r.hit = 1;
        else begin
          r.slot = link_in(it.sec);
          r.made = r.slot != 0;
        end
        if (it.op == OP_WRITE) begin
          if (r.slot != 0 && !wt_mode) dir_dirty[r.slot] = 1;
          r.need = wt_mode || r.slot == 0;
        end
      end
      OP_FLUSH: begin
        if (in_range) begin
          r.psec = dir_sector[it.sel];
          r.dirty = dir_hash[it.sel] != 0 && dir_dirty[it.sel];
          if (r.dirty) begin
            r.slot = it.sel;
            r.need = 1;
          end
        end else r.psec = NoneSector;
      end
      OP_CLEAN: if (in_range) dir_dirty[it.sel] = 0;
      default: ;
    endcase
    r.total = dir_count;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    if (rst) begin
      start <= 0;
    end else if (start && !took) begin
    end else if (gap > 0) begin
      gap <= gap - 1;
      start <= 0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      gap <= $urandom_range(0, 13);
      start <= 0;
    end else if (pending.size() > 0) begin
      item_t it;
      it = pending.pop_front();
      start <= 1;
      opcode <= it.op;
      sector_number <= it.sec;
      slot_select <= it.sel;
    end else begin
      start <= 0;
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    item_t it;
    took <= start && !busy && !rst;
    if (!rst) begin
      stall = stall + 1;
      if (cfg_valid && cfg_ready) begin
        wt_mode = cfg_wt;
        cfg_writes++;
        stall = 0;
      end
      if (start && !busy) begin
        it = '{op: opcode, sec: sector_number, sel: slot_select};
        awaited.push_back(apply_item(it));
        stall = 0;
      end
      if (done) begin
        stall = 0;
        if (awaited.size() == 0) report_mismatch("unexpected result", 0, 0);
        else begin
          want = awaited.pop_front();
          if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
          if (slot !== want.slot) report_mismatch("slot", slot, want.slot);
          if (entry_made !== want.made) report_mismatch("entry_made", entry_made, want.made);
          if (need_backing_write !== want.need)
            report_mismatch("need_backing_write", need_backing_write, want.need);
          if (dirty_found !== want.dirty) report_mismatch("dirty_found", dirty_found, want.dirty);
          if (probed_sector !== want.psec)
            report_mismatch("probed_sector", probed_sector, want.psec);
          if (cached_total !== want.total)
            report_mismatch("cached_total", cached_total, want.total);
        end
      end
      if (stall >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending.size() > 0 || start || awaited.size() > 0 || busy);
    @(negedge clk);
  endtask

  task automatic write_mode(logic v);
    int seen;
    wait_idle();
    seen = cfg_writes;
    cfg_valid <= 1;
    cfg_wt <= v;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 0;
  endtask

  function automatic item_t mk(logic [2:0] op, logic [31:0] sec, logic [10:0] sel);
    return '{op: op, sec: sec, sel: sel};
  endfunction

  function automatic item_t random_item();
    item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) it.op = OP_LOOKUP;
    else if (r < 45) it.op = OP_FILL;
    else if (r < 70) it.op = OP_WRITE;
    else if (r < 85) it.op = OP_FLUSH;
    else if (r < 95) it.op = OP_CLEAN;
    else it.op = 3'($urandom_range(5, 7));
    it.sec = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, pool.size() - 1)]
                                          : $urandom;
    it.sel = ($urandom_range(0, 99) < 80) ? 11'($urandom_range(1, Slots))
                                          : 11'($urandom_range(0, 2047));
    return it;
  endfunction

  initial begin
    logic [31:0] k;
    rst = 1;
    start = 0;
    opcode = 0;
    sector_number = 0;
    slot_select = 0;
    cfg_valid = 0;
    cfg_wt = 0;
    for (int i = 0; i <= Slots; i++) begin
      dir_hash[i] = 0;
      dir_link[i] = 0;
      dir_sector[i] = NoneSector;
      dir_dirty[i] = 0;
    end
    dir_count = 0;
    wt_mode = 1;

    twins.push_back($urandom);
    while (twins.size() < 5) begin
      k = $urandom;
      if (home_of(k) == home_of(twins[0]) && k != twins[0]) twins.push_back(k);
    end
    pool = {32'h0, 32'hFFFF_FFFF};
    for (int i = 0; i < 4; i++) pool.push_back(twins[i]);
    for (int i = 0; i < 300; i++) pool.push_back($urandom);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    write_mode(0);
    pending.push_back(mk(OP_LOOKUP, 32'h0, 11'd0));
    pending.push_back(mk(OP_FILL, 32'h0, 11'd2047));
    pending.push_back(mk(OP_FILL, 32'hFFFF_FFFF, 11'd0));
    pending.push_back(mk(OP_FILL, 32'hFFFF_FFFF, 11'd0));
    pending.push_back(mk(OP_WRITE, 32'hFFFF_FFFF, 11'd0));
    pending.push_back(mk(OP_WRITE, 32'h1234_5678, 11'd0));
    for (int i = 0; i < 4; i++) pending.push_back(mk(OP_FILL, twins[i], 11'd0));
    pending.push_back(mk(OP_WRITE, twins[3], 11'd0));
    pending.push_back(mk(OP_LOOKUP, twins[2], 11'd0));
    pending.push_back(mk(OP_LOOKUP, twins[4], 11'd0));
    pending.push_back(mk(OP_FLUSH, 32'h0, 11'd0));
    pending.push_back(mk(OP_FLUSH, 32'h0, 11'd1024));
    pending.push_back(mk(OP_FLUSH, 32'h0, 11'd1025));
    pending.push_back(mk(OP_FLUSH, 32'hFFFF_FFFF, 11'd2047));
    pending.push_back(mk(OP_FLUSH, 32'h0, home_of(twins[0])));
    pending.push_back(mk(OP_CLEAN, 32'h0, home_of(twins[0])));
    pending.push_back(mk(OP_FLUSH, 32'h0, home_of(twins[0])));
    pending.push_back(mk(OP_CLEAN, 32'h0, 11'd0));
    pending.push_back(mk(OP_CLEAN, 32'h0, 11'd2047));
    pending.push_back(mk(3'd5, 32'hFFFF_FFFF, 11'd2047));
    pending.push_back(mk(3'd6, 32'h0, 11'd1));
    pending.push_back(mk(3'd7, 32'hA5A5_A5A5, 11'd1024));

    write_mode(1);
    repeat (480) pending.push_back(random_item());
    write_mode(0);
    repeat (480) pending.push_back(random_item());
    write_mode(1);
    quiet = 1;
    repeat (470) pending.push_back(random_item());

    wait_idle();
    repeat (200) @(negedge clk);
    if (errors == 0 && awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
